### rtl/fbea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbea_pkg
// Shared widths, constants, the per-transaction tag and the CORDIC angle table
// used by the five-bar elbow angle pipeline.
// ----------------------------------------------------------------------------
package fbea_pkg;

  localparam int STEPS = 16;   // CORDIC stages per unit, 8 to 32
  localparam int W     = 40;   // CORDIC x/y datapath width
  localparam int ZW    = 28;   // CORDIC angle accumulator width
  localparam int AW    = 27;   // angle width in 1/65536 degree
  localparam int RB    = 32;   // result bits of the square root
  localparam int SW    = 27;   // n +/- distal_left
  localparam int PW    = 54;   // squares
  localparam int NW    = 55;   // num and den

  localparam logic [29:0] K30 = 30'd652032874;

  localparam logic signed [AW-1:0] D90  = AW'(5898240);
  localparam logic signed [AW-1:0] D180 = AW'(11796480);
  localparam logic signed [AW-1:0] D360 = AW'(23592960);
  localparam logic signed [17:0] LIMIT = 18'sd69120;

  localparam logic [2:0] REG_HALF_BASE    = 3'd0;
  localparam logic [2:0] REG_CRANK_LEFT   = 3'd1;
  localparam logic [2:0] REG_CRANK_RIGHT  = 3'd2;
  localparam logic [2:0] REG_DISTAL_LEFT  = 3'd3;
  localparam logic [2:0] REG_DISTAL_RIGHT = 3'd4;

  typedef struct packed {
    logic                 valid;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] ang;
    logic                 nega;
    logic                 negb;
    logic                 zero;
    logic                 unreach;
  } tag_t;

  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = ZW'(2949120);
      5'd1:  r = ZW'(1740967);
      5'd2:  r = ZW'(919879);
      5'd3:  r = ZW'(466945);
      5'd4:  r = ZW'(234379);
      5'd5:  r = ZW'(117304);
      5'd6:  r = ZW'(58666);
      5'd7:  r = ZW'(29335);
      5'd8:  r = ZW'(14668);
      5'd9:  r = ZW'(7334);
      5'd10: r = ZW'(3667);
      5'd11: r = ZW'(1833);
      5'd12: r = ZW'(917);
      5'd13: r = ZW'(458);
      5'd14: r = ZW'(229);
      5'd15: r = ZW'(115);
      5'd16: r = ZW'(57);
      5'd17: r = ZW'(29);
      5'd18: r = ZW'(14);
      5'd19: r = ZW'(7);
      5'd20: r = ZW'(4);
      5'd21: r = ZW'(2);
      5'd22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/five_bar_elbow_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_bar_elbow_angle
// Distal link angle of a five-bar linkage from its two motor angles.
// ----------------------------------------------------------------------------
// Usage: an input transaction carries motor_angle_a and motor_angle_b
// (1/128 degree). Each gives exactly one output transaction with elbow_angle
// (1/128 degree) and status (1 when the position cannot be reached, with
// elbow_angle zero). Both channels use valid/ready.
// The user must write link lengths through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block does not enforce it. Unknown indexes are ignored.
// The datapath is a fixed chain of cells: two rotation CORDIC lanes, one
// vectoring CORDIC, two 32-step square root lanes and a second vectoring
// CORDIC, plus eight single-cycle stages including the output register.
// One transaction is accepted per cycle while the output is not stalled.
// When the output is stalled the whole chain holds, empty slots included,
// and in_ready falls with it. Synchronous reset empties the pipeline and
// loads the default link lengths.
// ----------------------------------------------------------------------------
module five_bar_elbow_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] motor_angle_a,
  input  logic signed [15:0] motor_angle_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] elbow_angle,
  output logic               status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import fbea_pkg::*;

  logic [15:0] half_base, crank_left, crank_right, distal_left, distal_right;
  logic        en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_base    <= 16'd517;
      crank_left   <= 16'd4306;
      crank_right  <= 16'd4306;
      distal_left  <= 16'd4375;
      distal_right <= 16'd4375;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_BASE:    half_base    <= cfg_data;
        REG_CRANK_LEFT:   crank_left   <= cfg_data;
        REG_CRANK_RIGHT:  crank_right  <= cfg_data;
        REG_DISTAL_LEFT:  distal_left  <= cfg_data;
        REG_DISTAL_RIGHT: distal_right <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: scale, wrap and fold the motor angles, seed the rotations.
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] a_in, b_in, a_w, b_w, a_r, b_r;
  logic                 na, nb;
  logic [45:0]          pa, pb;

  assign a_in = $signed({{2{motor_angle_a[15]}}, motor_angle_a, 9'd0});
  assign b_in = $signed({{2{motor_angle_b[15]}}, motor_angle_b, 9'd0});

  always_comb begin
    a_w = a_in;
    if (a_w > D180) a_w = a_w - D360;
    if (a_w < -D180) a_w = a_w + D360;
    na  = 1'b0;
    a_r = a_w;
    if (a_w > D90) begin
      a_r = a_w - D180;
      na  = 1'b1;
    end else if (a_w < -D90) begin
      a_r = a_w + D180;
      na  = 1'b1;
    end
    b_w = b_in;
    if (b_w > D180) b_w = b_w - D360;
    if (b_w < -D180) b_w = b_w + D360;
    nb  = 1'b0;
    b_r = b_w;
    if (b_w > D90) begin
      b_r = b_w - D180;
      nb  = 1'b1;
    end else if (b_w < -D90) begin
      b_r = b_w + D180;
      nb  = 1'b1;
    end
  end

  assign pa = crank_left * K30;
  assign pb = crank_right * K30;

  logic signed [W-1:0]  rax [STEPS+1];
  logic signed [W-1:0]  ray [STEPS+1];
  logic signed [ZW-1:0] raz [STEPS+1];
  logic signed [W-1:0]  rbx [STEPS+1];
  logic signed [W-1:0]  rby [STEPS+1];
  logic signed [ZW-1:0] rbz [STEPS+1];
  tag_t                 rtag [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rtag[0].valid <= 1'b0;
    end else if (en) begin
      rtag[0].valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rtag[0].a       <= a_in;
      rtag[0].ang     <= '0;
      rtag[0].nega    <= na;
      rtag[0].negb    <= nb;
      rtag[0].zero    <= 1'b0;
      rtag[0].unreach <= 1'b0;
      rax[0] <= W'(pa[45:16]);
      ray[0] <= '0;
      raz[0] <= ZW'(a_r);
      rbx[0] <= W'(pb[45:16]);
      rby[0] <= '0;
      rbz[0] <= ZW'(b_r);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    fbea_cordic_cell u_rot_a (
      .clk(clk), .rst(rst), .en(en), .vec(1'b0), .idx(5'(i)),
      .x_i(rax[i]), .y_i(ray[i]), .z_i(raz[i]), .tag_i(rtag[i]),
      .x_o(rax[i+1]), .y_o(ray[i+1]), .z_o(raz[i+1]), .tag_o(rtag[i+1])
    );
    fbea_cordic_cell u_rot_b (
      .clk(clk), .rst(rst), .en(en), .vec(1'b0), .idx(5'(i)),
      .x_i(rbx[i]), .y_i(rby[i]), .z_i(rbz[i]), .tag_i(rtag[i]),
      .x_o(rbx[i+1]), .y_o(rby[i+1]), .z_o(rbz[i+1]), .tag_o()
    );
  end

  // --------------------------------------------------------------------------
  // Stage 1: vector q between the elbows, folded into the right half-plane.
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  ax, ay, bx, by, qx, qy;
  logic signed [AW-1:0] q_ang;
  logic                 q_zero;

  assign ax     = rtag[STEPS].nega ? -rax[STEPS] : rax[STEPS];
  assign ay     = rtag[STEPS].nega ? -ray[STEPS] : ray[STEPS];
  assign bx     = rtag[STEPS].negb ? -rbx[STEPS] : rbx[STEPS];
  assign by     = rtag[STEPS].negb ? -rby[STEPS] : rby[STEPS];
  assign qx     = ax + W'({half_base, 15'd0}) - bx;
  assign qy     = ay - by;
  assign q_zero = (qx == '0) && (qy == '0);
  assign q_ang  = qy[W-1] ? -D180 : D180;

  logic signed [W-1:0]  vx [STEPS+1];
  logic signed [W-1:0]  vy [STEPS+1];
  logic signed [ZW-1:0] vz [STEPS+1];
  tag_t                 vtag [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vtag[0].valid <= 1'b0;
    end else if (en) begin
      vtag[0].valid <= rtag[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtag[0].a       <= rtag[STEPS].a;
      vtag[0].ang     <= '0;
      vtag[0].nega    <= rtag[STEPS].nega;
      vtag[0].negb    <= rtag[STEPS].negb;
      vtag[0].zero    <= q_zero;
      vtag[0].unreach <= 1'b0;
      if (qx[W-1]) begin
        vx[0] <= -qx;
        vy[0] <= -qy;
        vz[0] <= ZW'(q_ang);
      end else begin
        vx[0] <= qx;
        vy[0] <= qy;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    fbea_cordic_cell u_vec (
      .clk(clk), .rst(rst), .en(en), .vec(1'b1), .idx(5'(i)),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]), .tag_i(vtag[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1]), .tag_o(vtag[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stages 2 to 5: norm, law-of-cosines terms and the reachability check.
  // The 36-bit magnitude is scaled by the CORDIC gain in two 18-bit halves.
  // --------------------------------------------------------------------------
  tag_t        t2, t3, t4, t5;
  logic [47:0] p_lo, p_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      t5.valid <= 1'b0;
    end else if (en) begin
      t2.valid <= vtag[STEPS].valid;
      t3.valid <= t2.valid;
      t4.valid <= t3.valid;
      t5.valid <= t4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2.a       <= vtag[STEPS].a;
      t2.ang     <= vtag[STEPS].zero ? '0 : AW'(vz[STEPS]);
      t2.nega    <= vtag[STEPS].nega;
      t2.negb    <= vtag[STEPS].negb;
      t2.zero    <= vtag[STEPS].zero;
      t2.unreach <= 1'b0;
      p_lo <= vx[STEPS][17:0] * K30;
      p_hi <= vx[STEPS][35:18] * K30;
    end
  end

  logic [65:0]          nsum;
  logic [25:0]          n_len;
  logic signed [SW-1:0] s1, s2;

  assign nsum  = {p_hi, 18'd0} + 66'(p_lo);
  assign n_len = 26'((nsum[65:30] + 36'd512) >> 10);

  always_ff @(posedge clk) begin
    if (en) begin
      t3.a       <= t2.a;
      t3.ang     <= t2.ang;
      t3.nega    <= t2.nega;
      t3.negb    <= t2.negb;
      t3.zero    <= t2.zero;
      t3.unreach <= 1'b0;
      s1 <= $signed({1'b0, n_len}) + $signed(SW'({distal_left, 4'd0}));
      s2 <= $signed({1'b0, n_len}) - $signed(SW'({distal_left, 4'd0}));
    end
  end

  logic signed [PW-1:0] sq1, sq2, l4sq;

  always_ff @(posedge clk) begin
    if (en) begin
      t4.a       <= t3.a;
      t4.ang     <= t3.ang;
      t4.nega    <= t3.nega;
      t4.negb    <= t3.negb;
      t4.zero    <= t3.zero;
      t4.unreach <= 1'b0;
      sq1  <= PW'(s1 * s1);
      sq2  <= PW'(s2 * s2);
      l4sq <= $signed(PW'({distal_right, 4'd0} * {distal_right, 4'd0}));
    end
  end

  logic signed [NW-1:0] num, den;
  logic [NW-1:0]        anum, aden;
  logic                 unr;

  assign num  = NW'(sq1) - NW'(l4sq);
  assign den  = NW'(l4sq) - NW'(sq2);
  assign anum = num[NW-1] ? NW'(-num) : NW'(num);
  assign aden = den[NW-1] ? NW'(-den) : NW'(den);
  // Unreachable when den is zero or num and den have strictly opposite signs.
  assign unr  = (den == '0) ||
                (num > 0 && den[NW-1]) || (num[NW-1] && den > 0);

  logic [63:0] sn_v [RB+1];
  logic [63:0] sn_r [RB+1];
  logic [63:0] sd_v [RB+1];
  logic [63:0] sd_r [RB+1];
  tag_t        stag [RB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      t5.a       <= t4.a;
      t5.ang     <= t4.ang;
      t5.nega    <= t4.nega;
      t5.negb    <= t4.negb;
      t5.zero    <= t4.zero;
      t5.unreach <= unr;
      sn_v[0] <= {anum[47:0], 16'd0};
      sd_v[0] <= {aden[47:0], 16'd0};
    end
  end

  assign stag[0] = t5;
  assign sn_r[0] = '0;
  assign sd_r[0] = '0;

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    fbea_sqrt_cell u_sq_num (
      .clk(clk), .rst(rst), .en(en), .idx(5'(RB-1-j)),
      .v_i(sn_v[j]), .r_i(sn_r[j]), .tag_i(stag[j]),
      .v_o(sn_v[j+1]), .r_o(sn_r[j+1]), .tag_o(stag[j+1])
    );
    fbea_sqrt_cell u_sq_den (
      .clk(clk), .rst(rst), .en(en), .idx(5'(RB-1-j)),
      .v_i(sd_v[j]), .r_i(sd_r[j]), .tag_i(stag[j]),
      .v_o(sd_v[j+1]), .r_o(sd_r[j+1]), .tag_o()
    );
  end

  // --------------------------------------------------------------------------
  // Stage 6: half angle as atan2(sqrt|num|, sqrt|den|).
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  gx [STEPS+1];
  logic signed [W-1:0]  gy [STEPS+1];
  logic signed [ZW-1:0] gz [STEPS+1];
  tag_t                 gtag [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gtag[0].valid <= 1'b0;
    end else if (en) begin
      gtag[0].valid <= stag[RB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gtag[0].a       <= stag[RB].a;
      gtag[0].ang     <= stag[RB].ang;
      gtag[0].nega    <= stag[RB].nega;
      gtag[0].negb    <= stag[RB].negb;
      gtag[0].zero    <= stag[RB].zero;
      gtag[0].unreach <= stag[RB].unreach;
      gx[0] <= W'(sd_r[RB][32:0]);
      gy[0] <= W'(sn_r[RB][32:0]);
      gz[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_half
    fbea_cordic_cell u_half (
      .clk(clk), .rst(rst), .en(en), .vec(1'b1), .idx(5'(i)),
      .x_i(gx[i]), .y_i(gy[i]), .z_i(gz[i]), .tag_i(gtag[i]),
      .x_o(gx[i+1]), .y_o(gy[i+1]), .z_o(gz[i+1]), .tag_o(gtag[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 7: sum, round to 1/128 degree, saturate; output register.
  // --------------------------------------------------------------------------
  logic signed [29:0] tsum, tround;
  logic signed [17:0] res;

  assign tsum   = 30'(gtag[STEPS].ang) - 30'(gtag[STEPS].a) + 30'(gz[STEPS]) * 30'sd2;
  assign tround = (tsum + 30'sd256) >>> 9;

  always_comb begin
    if (tround > 30'(LIMIT)) begin
      res = LIMIT;
    end else if (tround < -30'(LIMIT)) begin
      res = -LIMIT;
    end else begin
      res = tround[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= gtag[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elbow_angle <= gtag[STEPS].unreach ? '0 : res;
      status      <= gtag[STEPS].unreach;
    end
  end

  a_unreach_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> elbow_angle == '0)
    else $error("unreachable result carries a non-zero angle");

  a_limit : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (elbow_angle <= LIMIT) && (elbow_angle >= -LIMIT))
    else $error("elbow angle beyond saturation limit");

  a_stall : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

### rtl/fbea_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbea_cordic_cell
// One registered CORDIC micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module fbea_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vec,
  input  logic [4:0]                    idx,
  input  logic signed [fbea_pkg::W-1:0]  x_i,
  input  logic signed [fbea_pkg::W-1:0]  y_i,
  input  logic signed [fbea_pkg::ZW-1:0] z_i,
  input  fbea_pkg::tag_t                 tag_i,
  output logic signed [fbea_pkg::W-1:0]  x_o,
  output logic signed [fbea_pkg::W-1:0]  y_o,
  output logic signed [fbea_pkg::ZW-1:0] z_o,
  output fbea_pkg::tag_t                 tag_o
);
  import fbea_pkg::*;

  logic signed [W-1:0]  dx;
  logic signed [W-1:0]  dy;
  logic signed [ZW-1:0] da;
  logic                 up;

  assign dx = y_i >>> idx;
  assign dy = x_i >>> idx;
  assign da = atan_at(idx);
  assign up = vec ? y_i[W-1] : !z_i[ZW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else if (en) begin
      tag_o.valid <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_o.a       <= tag_i.a;
      tag_o.ang     <= tag_i.ang;
      tag_o.nega    <= tag_i.nega;
      tag_o.negb    <= tag_i.negb;
      tag_o.zero    <= tag_i.zero;
      tag_o.unreach <= tag_i.unreach;
      if (up) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - da;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + da;
      end
    end
  end

endmodule

### rtl/fbea_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbea_sqrt_cell
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module fbea_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [4:0]     idx,
  input  logic [63:0]    v_i,
  input  logic [63:0]    r_i,
  input  fbea_pkg::tag_t tag_i,
  output logic [63:0]    v_o,
  output logic [63:0]    r_o,
  output fbea_pkg::tag_t tag_o
);
  import fbea_pkg::*;

  logic [63:0] b;
  logic [63:0] t;
  logic        ge;

  assign b  = 64'd1 << {idx, 1'b0};
  assign t  = r_i + b;
  assign ge = v_i >= t;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else if (en) begin
      tag_o.valid <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_o.a       <= tag_i.a;
      tag_o.ang     <= tag_i.ang;
      tag_o.nega    <= tag_i.nega;
      tag_o.negb    <= tag_i.negb;
      tag_o.zero    <= tag_i.zero;
      tag_o.unreach <= tag_i.unreach;
      v_o <= ge ? (v_i - t) : v_i;
      r_o <= ge ? ((r_i >> 1) + b) : (r_i >> 1);
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the five-bar elbow angle pipeline.
// ----------------------------------------------------------------------------
// Motor angle pairs are sent over the input handshake. Each accepted pair is
// run through an integer kinematics predictor, and the result is queued. Every
// output transaction is checked in order against that queue. The run covers
// directed corner angles, extreme and random link lengths, random traffic
// with several idle and stall mixes, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import fbea_pkg::*;

  localparam int        HALF_PERIOD = 6;
  localparam int        SETTLE      = 120;   // longer than the pipeline latency
  localparam logic [2:0] REG_SPARE  = 3'd7;  // decodes to no register
  localparam longint    DEG         = 65536;
  localparam longint    GAIN        = 652032874;
  localparam longint    LIM         = 69120;
  localparam longint    ARC_DEG [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  typedef struct {
    logic signed [17:0] angle;
    logic               unreach;
  } elbow_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] motor_angle_a;
  logic signed [15:0] motor_angle_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [17:0] elbow_angle;
  logic               status;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  logic [15:0] link_len [0:4];   // predictor copy of the registers
  elbow_t      pending_elbows[$];
  int          send_gap_pct;
  int          stall_pct;
  int          hold_cycles;
  int          mismatches;
  int          errors;
  int          pairs_sent;
  int          elbows_checked;
  int          unreach_seen;

  five_bar_elbow_angle DUT (.*);

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Shift-and-add CORDIC, rotating (z to zero) or vectoring (y to zero).
  function automatic void cordic_run(inout longint x, inout longint y, inout longint z,
                                     input bit vectoring);
    longint dx;
    longint dy;
    bit     up;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      up = vectoring ? (y < 0) : (z >= 0);
      if (up) begin
        x -= dx; y += dy; z -= ARC_DEG[i];
      end else begin
        x += dx; y -= dy; z += ARC_DEG[i];
      end
    end
  endfunction

  function automatic void crank_tip(input logic [15:0] len, input longint ang,
                                    output longint cx, output longint sy);
    longint x;
    longint y;
    bit     flip;
    x = longint'((longint'(len) * GAIN) >> 16);
    y = 0;
    flip = 1'b0;
    if (ang > 180 * DEG) ang -= 360 * DEG;
    if (ang < -180 * DEG) ang += 360 * DEG;
    if (ang > 90 * DEG) begin
      ang -= 180 * DEG; flip = 1'b1;
    end else if (ang < -90 * DEG) begin
      ang += 180 * DEG; flip = 1'b1;
    end
    cordic_run(x, y, ang, 1'b0);
    cx = flip ? -x : x;
    sy = flip ? -y : y;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic elbow_t predict_elbow(input logic signed [15:0] ma,
                                           input logic signed [15:0] mb);
    elbow_t          e;
    longint          a, b, ax, ay, bx, by, qx, qy, ang, n, l3, l4, num, den;
    longint          gx, gy, g, t, r;
    longint unsigned norm;
    a = longint'(ma) * 512;
    b = longint'(mb) * 512;
    crank_tip(link_len[REG_CRANK_LEFT], a, ax, ay);
    crank_tip(link_len[REG_CRANK_RIGHT], b, bx, by);
    qx = ax + (longint'(link_len[REG_HALF_BASE]) <<< 15) - bx;
    qy = ay - by;
    ang = 0;
    norm = 0;
    if (qx != 0 || qy != 0) begin
      // Vector in the left half-plane: mirror it and start from +-180 degrees.
      if (qx < 0) begin
        ang = (qy >= 0) ? 180 * DEG : -180 * DEG;
        qx = -qx;
        qy = -qy;
      end
      cordic_run(qx, qy, ang, 1'b1);
      norm = (longint'(qx) * GAIN) >> 30;
    end
    n = longint'((norm + 512) >> 10);
    l3 = longint'(link_len[REG_DISTAL_LEFT]) <<< 4;
    l4 = longint'(link_len[REG_DISTAL_RIGHT]) <<< 4;
    num = (n + l3) * (n + l3) - l4 * l4;
    den = l4 * l4 - (n - l3) * (n - l3);
    if (den == 0 || (num > 0 && den < 0) || (num < 0 && den > 0)) begin
      e.angle = '0;
      e.unreach = 1'b1;
      return e;
    end
    gx = longint'(root_floor(longint'(den < 0 ? -den : den) << 16));
    gy = longint'(root_floor(longint'(num < 0 ? -num : num) << 16));
    g = 0;
    cordic_run(gx, gy, g, 1'b1);
    t = ang - a + 2 * g;
    r = (t + 256) >>> 9;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    e.angle = 18'(r);
    e.unreach = 1'b0;
    return e;
  endfunction

  // Called at a falling edge; leaves valid high for a following transaction.
  task automatic send_pair(input logic signed [15:0] ma, input logic signed [15:0] mb);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    motor_angle_a <= ma;
    motor_angle_b <= mb;
    do @(posedge clk); while (!in_ready);
    pending_elbows.push_back(predict_elbow(ma, mb));
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count)
      send_pair(16'($signed($urandom_range(46080)) - 23040),
                16'($signed($urandom_range(46080)) - 23040));
  endtask

  // Lower valid and wait for the pipeline to empty and settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_elbows.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_DISTAL_RIGHT) link_len[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_links(input logic [15:0] hb, input logic [15:0] cl,
                           input logic [15:0] cr, input logic [15:0] dl,
                           input logic [15:0] dr);
    write_reg(REG_HALF_BASE, hb);
    write_reg(REG_CRANK_LEFT, cl);
    write_reg(REG_CRANK_RIGHT, cr);
    write_reg(REG_DISTAL_LEFT, dl);
    write_reg(REG_DISTAL_RIGHT, dr);
  endtask

  task automatic test_directed_angles;
    logic signed [15:0] corner [0:9];
    corner = '{16'sd0, -16'sd1, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
               16'sd11521, -16'sd11521, 16'sd5760, -16'sd17280};
    send_gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 10; i++) send_pair(corner[i], corner[9 - i]);
    send_pair(16'sd23040, -16'sd23040);
    send_pair(-16'sd23040, 16'sd23040);
    send_pair(16'sd0, 16'sd23040);
    drain();
  endtask

  // Register extremes: zero lengths (zero vector, zero denominator), full
  // scale, a square layout, and a layout that puts the elbow on a boundary.
  task automatic test_link_extremes;
    set_links(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd11520, -16'sd4000);
    drain();
    set_links(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd23040, 16'sd0);
    send_pair(-16'sd1, 16'sd11520);
    drain();
    set_links(16'd0, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd7000, 16'sd7000);
    drain();
    set_links(16'd0, 16'd4000, 16'd0, 16'd2000, 16'd6000);
    send_pair(16'sd0, 16'sd100);
    drain();
    // A write to an index with no register must change nothing.
    write_reg(REG_SPARE, 16'h1234);
    set_links(16'd517, 16'd4306, 16'd4306, 16'd4375, 16'd4375);
    send_random(4);
    drain();
  endtask

  task automatic test_random_traffic;
    int gap_mix [0:3];
    int stall_mix [0:3];
    gap_mix   = '{0, 63, 0, 15};
    stall_mix = '{0, 0, 63, 15};
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gap_mix[p];
      stall_pct    = stall_mix[p];
      if (p != 0) begin
        set_links(16'($urandom_range(0, 3000)), 16'($urandom_range(1000, 8000)),
                  16'($urandom_range(1000, 8000)), 16'($urandom_range(2000, 9000)),
                  16'($urandom_range(2000, 9000)));
      end
      send_random(170);
      drain();
    end
  endtask

  // Hold the output off long enough that the pipeline fills and in_ready
  // falls, while new pairs keep being offered.
  task automatic test_output_holdoff;
    send_gap_pct = 0;
    stall_pct = 15;
    hold_cycles = 300;
    send_random(140);
    drain();
  endtask

  task automatic test_pause_and_resume;
    send_gap_pct = 15;
    stall_pct = 15;
    send_random(30);
    drain();
    send_random(30);
    drain();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    elbow_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_elbows.size() == 0) begin
        errors++;
        if (errors + mismatches <= 10)
          $display("unexpected transaction: elbow_angle %0d status %0d",
                   elbow_angle, status);
      end else begin
        e = pending_elbows.pop_front();
        elbows_checked++;
        if (status) unreach_seen++;
        if (elbow_angle !== e.angle || status !== e.unreach) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected angle %0d status %0d, got angle %0d status %0d",
                     e.angle, e.unreach, elbow_angle, status);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    motor_angle_a = '0;
    motor_angle_b = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_cycles = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    errors = 0;
    pairs_sent = 0;
    elbows_checked = 0;
    unreach_seen = 0;
    link_len = '{16'd517, 16'd4306, 16'd4306, 16'd4375, 16'd4375};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_angles();
    test_link_extremes();
    test_random_traffic();
    test_output_holdoff();
    test_pause_and_resume();

    errors += pending_elbows.size();
    $display("Sent %0d angle pairs, checked %0d results (%0d unreachable),",
             pairs_sent, elbows_checked, unreach_seen);
    $display("over default, extreme and random link lengths with idling and stalls.");
    if (mismatches == 0 && errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
